FILE: design/lfps_pkg.sv
// Shared types, constants and register codes of the line-follow PID steering block.
package lfps_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int END_FRAMES   = 5;

    localparam int IR_W       = 10;
    localparam int ERR_W      = 15;
    localparam int DELTA_W    = ERR_W + 1;
    localparam int GAIN_W     = 32;
    localparam int SPD_W      = 16;
    localparam int WF_W       = 3;
    localparam int INTEG_W    = 48;
    localparam int PE_W       = GAIN_W + ERR_W;
    localparam int DE_W       = GAIN_W + DELTA_W;
    localparam int SUM_W      = 50;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Correction divisor 4096000 = 2^15 * 125. Magnitude is shifted by 15,
    // clipped to 24 bits (anything larger saturates both wheels anyway),
    // then divided by 125 with a reciprocal multiply.
    localparam int MAG_SHIFT   = 15;
    localparam int QX_W        = 24;
    localparam int RECIP_W     = 26;
    localparam int RECIP_SHIFT = 32;
    localparam int Q_W         = 18;
    localparam int CORR_W      = Q_W + 1;
    localparam int SPDX_W      = SPD_W + 4;
    localparam logic [RECIP_W-1:0] RECIP_125 = 26'd34359739;

    localparam logic [IR_W-1:0] CARPET_LOW  = 10'd300;
    localparam logic [IR_W-1:0] CARPET_HIGH = 10'd400;

    localparam logic signed [ERR_W-1:0] WEIGHTS [SENSOR_COUNT] = '{
        -15'sd4000, -15'sd3000, -15'sd2000, -15'sd1000,
         15'sd1000,  15'sd2000,  15'sd3000,  15'sd4000
    };

    localparam logic [IR_W-1:0]          WHITE_THR_RST = 10'd800;
    localparam logic signed [GAIN_W-1:0] KP_RST        = 32'sd13421773;
    localparam logic signed [GAIN_W-1:0] KI_RST        = 32'sd0;
    localparam logic signed [GAIN_W-1:0] KD_RST        = 32'sd0;
    localparam logic [SPD_W-1:0]         BASE_RST      = 16'd12288;
    localparam logic [SPD_W-1:0]         MAX_RST       = 16'd40960;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WHITE_THR  = 3'd0,
        CFG_PROP_GAIN  = 3'd1,
        CFG_INTEG_GAIN = 3'd2,
        CFG_DERIV_GAIN = 3'd3,
        CFG_BASE_SPEED = 3'd4,
        CFG_MAX_SPEED  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [IR_W-1:0]          white_thr;
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        logic [SPD_W-1:0]         base;
        logic [SPD_W-1:0]         max;
    } t_cfg;

    typedef logic [SENSOR_COUNT-1:0][IR_W-1:0] t_frame;

    // Per-frame tag carried down the pipe to the result
    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic                    done;
        logic                    carpet;
    } t_tag;

    typedef struct packed {
        t_tag                      tag;
        logic signed [DELTA_W-1:0] delta;
    } t_front_item;

    typedef struct packed {
        t_tag                    tag;
        logic signed [SUM_W-1:0] sum;
    } t_pid_item;

    typedef struct packed {
        t_tag             tag;
        logic [SPD_W-1:0] left;
        logic [SPD_W-1:0] right;
    } t_result;

endpackage

FILE: design/line_follow_pid_steering_top.sv
// Top level of the line-follow PID steering block: config registers and pipeline.
//
// Input channel: one transaction carries one frame of eight 10-bit IR readings
// (i_ir_0 leftmost .. i_ir_7 rightmost), taken when i_valid is high and o_stall
// low. Output channel: one transaction per frame carrying left/right wheel
// speeds (Q4.12), the weighted line error and the end/carpet flags, taken when
// o_valid is high and i_stall low.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_idx (threshold, Kp, Ki,
// Kd, base speed, max speed). Indexes past the last register are ignored.
// Write config only while no frame is in flight.
// Pipeline: seven register stages (input, error, products, PID sum, magnitude,
// quotient, output). Throughput: one frame per cycle while the output is not
// stalled; the error history and integral are each updated through a feedback
// loop around a single register.
// Each stage holds when the stage after it is full and blocked, so a stalled
// output still lets frames enter until the pipe is full; o_stall then rises.
// Reset (synchronous, active low) empties the pipe, loads default gains and
// speeds, and clears the previous error, integral and white-frame count.
module line_follow_pid_steering_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lfps_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [lfps_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [lfps_pkg::IR_W-1:0]            i_ir_0,
    input  logic [lfps_pkg::IR_W-1:0]            i_ir_1,
    input  logic [lfps_pkg::IR_W-1:0]            i_ir_2,
    input  logic [lfps_pkg::IR_W-1:0]            i_ir_3,
    input  logic [lfps_pkg::IR_W-1:0]            i_ir_4,
    input  logic [lfps_pkg::IR_W-1:0]            i_ir_5,
    input  logic [lfps_pkg::IR_W-1:0]            i_ir_6,
    input  logic [lfps_pkg::IR_W-1:0]            i_ir_7,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [lfps_pkg::SPD_W-1:0]           o_left_speed,
    output logic [lfps_pkg::SPD_W-1:0]           o_right_speed,
    output logic signed [lfps_pkg::ERR_W-1:0]    o_line_error,
    output logic                                 o_end_reached,
    output logic                                 o_carpet_seen
);
    import lfps_pkg::*;

    t_cfg        r_cfg;
    t_frame      frame;
    logic        front_ready;
    logic        front_valid;
    t_front_item front_item;
    logic        pid_ready;
    logic        pid_valid;
    t_pid_item   pid_item;
    logic        scale_ready;
    t_result     result;

    // register file; unknown indexes fall to the default arm
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.white_thr <= WHITE_THR_RST;
            r_cfg.kp        <= KP_RST;
            r_cfg.ki        <= KI_RST;
            r_cfg.kd        <= KD_RST;
            r_cfg.base      <= BASE_RST;
            r_cfg.max       <= MAX_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WHITE_THR:  r_cfg.white_thr <= i_cfg_data[IR_W-1:0];
                CFG_PROP_GAIN:  r_cfg.kp        <= $signed(i_cfg_data[GAIN_W-1:0]);
                CFG_INTEG_GAIN: r_cfg.ki        <= $signed(i_cfg_data[GAIN_W-1:0]);
                CFG_DERIV_GAIN: r_cfg.kd        <= $signed(i_cfg_data[GAIN_W-1:0]);
                CFG_BASE_SPEED: r_cfg.base      <= i_cfg_data[SPD_W-1:0];
                CFG_MAX_SPEED:  r_cfg.max       <= i_cfg_data[SPD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign frame[0] = i_ir_0;
    assign frame[1] = i_ir_1;
    assign frame[2] = i_ir_2;
    assign frame[3] = i_ir_3;
    assign frame[4] = i_ir_4;
    assign frame[5] = i_ir_5;
    assign frame[6] = i_ir_6;
    assign frame[7] = i_ir_7;

    lfps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .o_ready (front_ready),
        .i_frame (frame),
        .o_valid (front_valid),
        .i_ready (pid_ready),
        .o_item  (front_item)
    );

    lfps_pid u_pid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (front_valid),
        .o_ready (pid_ready),
        .i_item  (front_item),
        .o_valid (pid_valid),
        .i_ready (scale_ready),
        .o_item  (pid_item)
    );

    lfps_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (pid_valid),
        .o_ready  (scale_ready),
        .i_item   (pid_item),
        .o_valid  (o_valid),
        .i_ready  (!i_stall),
        .o_result (result)
    );

    assign o_stall       = !front_ready;
    assign o_left_speed  = result.left;
    assign o_right_speed = result.right;
    assign o_line_error  = result.tag.err;
    assign o_end_reached = result.tag.done;
    assign o_carpet_seen = result.tag.carpet;

endmodule

FILE: design/lfps_front.sv
// Sensor thresholding, weighted line error, end/carpet detection and error history.
module lfps_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lfps_pkg::t_cfg        i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  lfps_pkg::t_frame      i_frame,
    output logic                  o_valid,
    input  logic                  i_ready,
    output lfps_pkg::t_front_item o_item
);
    import lfps_pkg::*;

    logic                    r_a_v;
    t_frame                  r_a_frame;
    logic                    r_b_v;
    t_front_item             r_b_item;
    logic signed [ERR_W-1:0] r_prev_err, n_prev_err;
    logic [WF_W-1:0]         r_wf, n_wf;

    logic [SENSOR_COUNT-1:0] hit;
    logic [SENSOR_COUNT-1:0] in_carpet;
    logic signed [ERR_W-1:0] err;
    logic                    all_white;
    logic                    carpet;
    logic                    done;
    logic [WF_W-1:0]         wf_inc;
    t_front_item             item;
    logic                    rdy_b;
    logic                    move_ab;

    assign rdy_b   = !r_b_v || i_ready;
    assign o_ready = !r_a_v || rdy_b;
    assign move_ab = r_a_v && rdy_b;

    always_comb begin
        err = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            hit[i]       = (r_a_frame[i] >= i_cfg.white_thr);
            in_carpet[i] = (r_a_frame[i] > CARPET_LOW) && (r_a_frame[i] < CARPET_HIGH);
            if (hit[i]) begin
                err = err + WEIGHTS[i];
            end
        end
        all_white = &hit;
        carpet    = &in_carpet;
        wf_inc    = r_wf + 1'b1;
        done      = all_white && (wf_inc >= WF_W'(END_FRAMES));

        item.tag.err    = err;
        item.tag.done   = done;
        item.tag.carpet = carpet;
        item.delta      = {err[ERR_W-1], err} - {r_prev_err[ERR_W-1], r_prev_err};

        n_prev_err = r_prev_err;
        n_wf       = r_wf;
        if (move_ab) begin
            if (done || carpet) begin
                n_prev_err = '0;
                n_wf       = '0;
            end else begin
                n_prev_err = err;
                if (all_white) begin
                    n_wf = wf_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v      <= 1'b0;
            r_b_v      <= 1'b0;
            r_prev_err <= '0;
            r_wf       <= '0;
        end else begin
            if (o_ready) begin
                r_a_v <= i_valid;
            end
            if (rdy_b) begin
                r_b_v <= r_a_v;
            end
            r_prev_err <= n_prev_err;
            r_wf       <= n_wf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_a_frame <= i_frame;
        end
        if (move_ab) begin
            r_b_item <= item;
        end
    end

    assign o_valid = r_b_v;
    assign o_item  = r_b_item;

endmodule

FILE: design/lfps_pid.sv
// PID terms: three gain multiplies, saturating integral and the summed correction.
module lfps_pid (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lfps_pkg::t_cfg        i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  lfps_pkg::t_front_item i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output lfps_pkg::t_pid_item   o_item
);
    import lfps_pkg::*;

    logic                      r_c_v;
    t_tag                      r_c_tag;
    logic signed [PE_W-1:0]    r_c_pe;
    logic signed [PE_W-1:0]    r_c_ie;
    logic signed [DE_W-1:0]    r_c_de;
    logic                      r_d_v;
    t_pid_item                 r_d_item;
    logic signed [INTEG_W-1:0] r_integ, n_integ;

    logic signed [PE_W-1:0]    pe;
    logic signed [PE_W-1:0]    ie;
    logic signed [DE_W-1:0]    de;
    logic signed [INTEG_W:0]   i_full;
    logic signed [INTEG_W-1:0] i_term;
    t_pid_item                 item;
    logic                      rdy_d;
    logic                      move_cd;

    assign rdy_d   = !r_d_v || i_ready;
    assign o_ready = !r_c_v || rdy_d;
    assign move_cd = r_c_v && rdy_d;

    assign pe = PE_W'($signed(i_cfg.kp)) * PE_W'($signed(i_item.tag.err));
    assign ie = PE_W'($signed(i_cfg.ki)) * PE_W'($signed(i_item.tag.err));
    assign de = DE_W'($signed(i_cfg.kd)) * DE_W'($signed(i_item.delta));

    always_comb begin
        i_full = (INTEG_W+1)'(r_c_ie) + (INTEG_W+1)'(r_integ);
        // saturate to the 48-bit signed range
        if (i_full[INTEG_W] != i_full[INTEG_W-1]) begin
            i_term = {i_full[INTEG_W], {(INTEG_W-1){~i_full[INTEG_W]}}};
        end else begin
            i_term = i_full[INTEG_W-1:0];
        end
        item.tag = r_c_tag;
        item.sum = SUM_W'(r_c_pe) + SUM_W'(i_term) + SUM_W'(r_c_de);

        n_integ = r_integ;
        if (move_cd) begin
            n_integ = (r_c_tag.done || r_c_tag.carpet) ? '0 : i_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v   <= 1'b0;
            r_d_v   <= 1'b0;
            r_integ <= '0;
        end else begin
            if (o_ready) begin
                r_c_v <= i_valid;
            end
            if (rdy_d) begin
                r_d_v <= r_c_v;
            end
            r_integ <= n_integ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_c_tag <= i_item.tag;
            r_c_pe  <= pe;
            r_c_ie  <= ie;
            r_c_de  <= de;
        end
        if (move_cd) begin
            r_d_item <= item;
        end
    end

    assign o_valid = r_d_v;
    assign o_item  = r_d_item;

endmodule

FILE: design/lfps_scale.sv
// Correction scaling (divide by 4096000, toward zero) and clamped wheel speeds.
module lfps_scale (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lfps_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  lfps_pkg::t_pid_item i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output lfps_pkg::t_result   o_result
);
    import lfps_pkg::*;

    localparam int XS_W   = SUM_W - MAG_SHIFT;
    localparam int PROD_W = QX_W + RECIP_W;

    logic                     r_e_v;
    t_tag                     r_e_tag;
    logic [QX_W-1:0]          r_e_x;
    logic                     r_e_neg;
    logic                     r_f_v;
    t_tag                     r_f_tag;
    logic signed [CORR_W-1:0] r_f_corr;
    logic                     r_g_v;
    t_result                  r_g_res;

    logic                     neg;
    logic [SUM_W-1:0]         mag;
    logic [XS_W-1:0]          xs;
    logic [QX_W-1:0]          x;
    logic [PROD_W-1:0]        prod;
    logic [Q_W-1:0]           q;
    logic signed [CORR_W-1:0] corr;
    logic signed [SPDX_W-1:0] base_x;
    logic signed [SPDX_W-1:0] corr_x;
    logic signed [SPDX_W-1:0] left_x;
    logic signed [SPDX_W-1:0] right_x;
    t_result                  res;
    logic                     rdy_f;
    logic                     rdy_g;

    function automatic logic [SPD_W-1:0] clamp_speed(input logic signed [SPDX_W-1:0] v,
                                                     input logic [SPD_W-1:0] vmax);
        logic [SPD_W-1:0] r;
        if (v[SPDX_W-1]) begin
            r = '0;
        end else if (v[SPDX_W-2:0] > (SPDX_W-1)'(vmax)) begin
            r = vmax;
        end else begin
            r = v[SPD_W-1:0];
        end
        return r;
    endfunction

    assign rdy_g   = !r_g_v || i_ready;
    assign rdy_f   = !r_f_v || rdy_g;
    assign o_ready = !r_e_v || rdy_f;

    // magnitude, pre-shift and clip
    always_comb begin
        neg = i_item.sum[SUM_W-1];
        mag = neg ? SUM_W'(-i_item.sum) : SUM_W'(i_item.sum);
        xs  = mag[SUM_W-1:MAG_SHIFT];
        x   = (|xs[XS_W-1:QX_W]) ? '1 : xs[QX_W-1:0];
    end

    // divide by 125 through the reciprocal, restore the sign
    always_comb begin
        prod = PROD_W'(r_e_x) * PROD_W'(RECIP_125);
        q    = prod[RECIP_SHIFT +: Q_W];
        corr = r_e_neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end

    always_comb begin
        base_x    = $signed({{(SPDX_W-SPD_W){1'b0}}, i_cfg.base});
        corr_x    = $signed({{(SPDX_W-CORR_W){r_f_corr[CORR_W-1]}}, r_f_corr});
        left_x    = base_x + corr_x;
        right_x   = base_x - corr_x;
        res.tag   = r_f_tag;
        res.left  = clamp_speed(left_x, i_cfg.max);
        res.right = clamp_speed(right_x, i_cfg.max);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
        end else begin
            if (o_ready) begin
                r_e_v <= i_valid;
            end
            if (rdy_f) begin
                r_f_v <= r_e_v;
            end
            if (rdy_g) begin
                r_g_v <= r_f_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_e_tag <= i_item.tag;
            r_e_x   <= x;
            r_e_neg <= neg;
        end
        if (rdy_f && r_e_v) begin
            r_f_tag  <= r_e_tag;
            r_f_corr <= corr;
        end
        if (rdy_g && r_f_v) begin
            r_g_res <= res;
        end
    end

    assign o_valid  = r_g_v;
    assign o_result = r_g_res;

endmodule

FILE: design/lfps_checker.sv
// Port-level checks of the line-follow PID steering block and their bind.
module lfps_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic [lfps_pkg::SPD_W-1:0]        o_left_speed,
    input logic [lfps_pkg::SPD_W-1:0]        o_right_speed,
    input logic signed [lfps_pkg::ERR_W-1:0] o_line_error,
    input logic                              o_end_reached,
    input logic                              o_carpet_seen
);

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a stalled result stays put
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_left_speed) && $stable(o_right_speed)
            && $stable(o_line_error) && $stable(o_end_reached) && $stable(o_carpet_seen))
        else $error("stalled result changed");

    // error is a sum of eight weights of at most 4000
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_line_error >= -15'sd10000) && (o_line_error <= 15'sd10000))
        else $error("line error out of range");

    // end is only flagged on an all-white frame, whose weights cancel
    a_end_zero_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_reached |-> o_line_error == '0)
        else $error("end flagged with nonzero error");

endmodule

bind line_follow_pid_steering_top lfps_checker u_lfps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_left_speed  (o_left_speed),
    .o_right_speed (o_right_speed),
    .o_line_error  (o_line_error),
    .o_end_reached (o_end_reached),
    .o_carpet_seen (o_carpet_seen)
);
